FILE: rtl/hough_line_rasterizer_unit_assert.svh
// Assertion macros shared by the checker.
`ifndef HOUGH_LINE_RASTERIZER_UNIT_ASSERT_SVH
`define HOUGH_LINE_RASTERIZER_UNIT_ASSERT_SVH

// Consequence holds in the same cycle as the antecedent.
`define HLR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence holds in the cycle after the antecedent.
`define HLR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/hlr_pkg.sv
package hlr_pkg;

    localparam int MAX_DIM_DEF    = 1024;
    localparam int ANGLE_BITS_DEF = 12;
    localparam int COORD_BITS_DEF = 22;

    localparam int SIN_ONE = 16384;
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    // Magnitude widths of the endpoint division.
    localparam int NUM_W = 44;
    localparam int DEN_W = 15;

    localparam logic [10:0] WIDTH_RESET  = 11'd640;
    localparam logic [10:0] HEIGHT_RESET = 11'd480;

    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_index_t;

    typedef enum logic [0:0] {
        OP_START   = 1'b0,
        OP_ADVANCE = 1'b1
    } op_t;

    // Shift and subtract quotient, used only while the sine ROM is built.
    function automatic longint unsigned udiv_u64(input longint unsigned num,
                                                 input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[62:0], num[i]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // One quarter-wave sine entry in Q1.14, from a truncating Taylor series in Q30.
    // Only evaluated at elaboration to fill the sine ROM.
    function automatic logic [14:0] quarter_entry(input int unsigned k,
                                                  input int unsigned qbits);
        longint unsigned q;
        longint unsigned kk;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned dv;
        longint signed   sum;
        longint signed   r;
        q  = 64'd1 << qbits;
        kk = longint'(k);
        if (kk > q)
            kk = q;
        x    = (PI_Q30 * kk) >> (qbits + 1);
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 7; n++)
        begin
            dv   = longint'((2 * n) * (2 * n + 1));
            term = udiv_u64((term * x2) >> 30, dv);
            if ((n & 1) == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        r = longint'((longint'(sum) + 64'sd32768) >>> 16);
        if (r > SIN_ONE)
            r = SIN_ONE;
        return r[14:0];
    endfunction

endpackage

FILE: rtl/hough_line_rasterizer_unit.sv
// Advance request: result registered in the cycle after acceptance; one advance per
// cycle unless a held result or a line set-up stalls the input. Start request: no result;
// the unit stalls while it reads sine and cosine, multiplies, runs one (vertical line) or
// two endpoint divisions on the one restoring divider shared by both, centres and arms.
// rst_n clears asynchronously: no line active, width 640, height 480, no result pending.
module hough_line_rasterizer_unit #(
    parameter int MAX_DIM    = hlr_pkg::MAX_DIM_DEF,
    parameter int ANGLE_BITS = hlr_pkg::ANGLE_BITS_DEF,
    parameter int COORD_BITS = hlr_pkg::COORD_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_write,
    input  logic [0:0]         cfg_index,
    input  logic [10:0]        cfg_data,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic               operation,
    input  logic signed [15:0] rho,
    input  logic [11:0]        angle,
    input  logic [7:0]         red_in,
    input  logic [7:0]         green_in,
    input  logic [7:0]         blue_in,

    output logic               out_valid,
    input  logic               out_stall,
    output logic               write_enable,
    output logic [9:0]         pixel_x,
    output logic [9:0]         pixel_y,
    output logic [19:0]        pixel_index,
    output logic [7:0]         red_out,
    output logic [7:0]         green_out,
    output logic [7:0]         blue_out,
    output logic               last
);

    localparam int Q      = 1 << (ANGLE_BITS - 2);
    localparam int ADDR_W = ANGLE_BITS - 1;
    localparam int SPAN_W = COORD_BITS + 1;
    localparam int ERR_W  = COORD_BITS + 3;
    localparam int NUM_W  = hlr_pkg::NUM_W;
    localparam int DEN_W  = hlr_pkg::DEN_W;
    localparam int QUO_W  = NUM_W + 1;
    localparam int CEN_W  = NUM_W + 2;
    localparam int CNT_W  = $clog2(NUM_W);

    localparam logic signed [CEN_W-1:0] COORD_HI =
        CEN_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [CEN_W-1:0] COORD_LO = -COORD_HI - CEN_W'(1);

    typedef logic [14:0] rom_t [0:Q];

    function automatic rom_t build_rom();
        rom_t t;
        for (int k = 0; k <= Q; k++)
        begin
            t[k] = hlr_pkg::quarter_entry(k, ANGLE_BITS - 2);
        end
        return t;
    endfunction

    localparam rom_t SIN_ROM = build_rom();

    typedef enum logic [2:0] {
        S_IDLE,
        S_SIN_RD,
        S_COS_RD,
        S_TRIG,
        S_MUL,
        S_DIV,
        S_CEN,
        S_ARM
    } state_t;

    state_t state_reg;

    logic [10:0]             width_reg, height_reg;
    logic [COORD_BITS-1:0]   cur_x_reg, cur_y_reg, end_x_reg, end_y_reg;
    logic [SPAN_W-1:0]       span_x_reg, span_y_reg;
    logic                    step_x_neg_reg, step_y_neg_reg;
    logic signed [ERR_W-1:0] err_reg;
    logic [23:0]             colour_reg;
    logic                    active_reg;

    logic [ANGLE_BITS-1:0]   angle_reg;
    logic signed [15:0]      rho_reg;
    logic signed [15:0]      sin_reg, cos_reg;
    logic signed [26:0]      prod_reg;
    logic                    vertical_reg;
    logic [NUM_W-1:0]        num_reg;
    logic [DEN_W-1:0]        rem_reg, den_reg;
    logic                    div_neg_reg, den_zero_reg, div_pass_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [1:0]              cen_reg;
    logic signed [QUO_W-1:0] q1_reg, q2_reg;
    logic [COORD_BITS-1:0]   px1_reg, py1_reg, px2_reg, py2_reg;

    logic                    out_valid_reg, we_reg, last_reg;
    logic [9:0]              px_out_reg, py_out_reg;
    logic [19:0]             index_reg;
    logic [23:0]             rgb_reg;

    logic [ADDR_W-1:0]       rom_addr;
    logic [14:0]             rom_data_reg;

    // ---------------- handshake ----------------
    logic in_accept, adv_accept;
    assign in_stall   = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign in_accept  = in_valid && !in_stall;
    assign adv_accept = in_accept && (operation == hlr_pkg::OP_ADVANCE);

    // ---------------- sine ROM ----------------
    logic [ANGLE_BITS-1:0] cos_angle;
    assign cos_angle = angle_reg + ANGLE_BITS'(Q);

    function automatic logic [ADDR_W-1:0] quad_addr(input logic [ANGLE_BITS-1:0] a);
        logic [ADDR_W-1:0] k;
        k = ADDR_W'(a[ANGLE_BITS-3:0]);
        return a[ANGLE_BITS-2] ? ADDR_W'(Q) - k : k;
    endfunction

    assign rom_addr = (state_reg == S_SIN_RD) ? quad_addr(angle_reg) : quad_addr(cos_angle);

    always_ff @(posedge clk)
    begin
        rom_data_reg <= SIN_ROM[rom_addr];
    end

    logic signed [15:0] rom_pos, rom_neg;
    assign rom_pos = $signed({1'b0, rom_data_reg});
    assign rom_neg = -rom_pos;

    // ---------------- divider ----------------
    logic signed [QUO_W-1:0] rho_q, num2;
    logic signed [15:0]      den_sel;
    logic [DEN_W:0]          trial;
    logic                    qbit;
    logic [NUM_W-1:0]        quo_mag;
    logic signed [QUO_W-1:0] quo;

    // The second numerator is rho * 2^14 - 16 * width * cos.
    assign rho_q   = {{(QUO_W - 30){rho_reg[15]}}, rho_reg, 14'd0};
    assign num2    = rho_q - $signed({{(QUO_W - 31){prod_reg[26]}}, prod_reg, 4'd0});
    assign den_sel = (sin_reg == 16'sd0) ? cos_reg : sin_reg;
    assign trial   = {rem_reg, num_reg[NUM_W-1]};
    assign qbit    = trial >= {1'b0, den_reg};
    assign quo_mag = {num_reg[NUM_W-2:0], qbit};
    assign quo     = den_zero_reg ? '0 :
                     (div_neg_reg ? -$signed({1'b0, quo_mag}) : $signed({1'b0, quo_mag}));

    function automatic logic [NUM_W-1:0] mag_of(input logic signed [QUO_W-1:0] v);
        logic signed [QUO_W-1:0] a;
        a = v[QUO_W-1] ? -v : v;
        return a[NUM_W-1:0];
    endfunction

    // ---------------- centring ----------------
    logic signed [CEN_W-1:0] cen_base, cen_off, cen_sum, cen_adj, cen_shift, cen_sat;
    logic                    cen_sub;

    always_comb
    begin
        cen_sub  = cen_reg[0];
        cen_base = cen_reg[0] ? CEN_W'({height_reg[10:1], 4'd0})
                              : CEN_W'({width_reg[10:1], 4'd0});
        case (cen_reg)
            2'd0:    cen_off = vertical_reg ? CEN_W'(q1_reg) : '0;
            2'd1:    cen_off = vertical_reg ? '0 : CEN_W'(q1_reg);
            2'd2:    cen_off = vertical_reg ? CEN_W'(q1_reg) : CEN_W'({width_reg, 4'd0});
            default: cen_off = vertical_reg ? CEN_W'({height_reg, 4'd0}) : CEN_W'(q2_reg);
        endcase
        cen_sum   = cen_sub ? cen_base - cen_off : cen_base + cen_off;
        // Truncation toward zero of a division by sixteen.
        cen_adj   = cen_sum[CEN_W-1] ? cen_sum + CEN_W'(15) : cen_sum;
        cen_shift = cen_adj >>> 4;
        if (cen_shift > COORD_HI)
            cen_sat = COORD_HI;
        else if (cen_shift < COORD_LO)
            cen_sat = COORD_LO;
        else
            cen_sat = cen_shift;
    end

    // ---------------- line set-up ----------------
    logic signed [COORD_BITS:0] dx, dy;
    logic [SPAN_W-1:0]          sx_new, sy_new;
    assign dx     = $signed({px2_reg[COORD_BITS-1], px2_reg})
                  - $signed({px1_reg[COORD_BITS-1], px1_reg});
    assign dy     = $signed({py2_reg[COORD_BITS-1], py2_reg})
                  - $signed({py1_reg[COORD_BITS-1], py1_reg});
    assign sx_new = dx[COORD_BITS] ? SPAN_W'(-dx) : SPAN_W'(dx);
    assign sy_new = dy[COORD_BITS] ? SPAN_W'(-dy) : SPAN_W'(dy);

    // ---------------- Bresenham step ----------------
    logic                    in_image, done, move_x, move_y;
    logic signed [ERR_W:0]   e2, neg_sy, sx_e;
    logic signed [ERR_W-1:0] err_step;
    logic [21:0]             row_base;
    logic [21:0]             idx_full;

    assign in_image = !cur_x_reg[COORD_BITS-1] && (cur_x_reg < COORD_BITS'(width_reg))
                   && !cur_y_reg[COORD_BITS-1] && (cur_y_reg < COORD_BITS'(height_reg));
    assign done   = (cur_x_reg == end_x_reg) && (cur_y_reg == end_y_reg);
    assign e2     = {err_reg, 1'b0};
    assign neg_sy = -$signed((ERR_W + 1)'(span_y_reg));
    assign sx_e   = $signed((ERR_W + 1)'(span_x_reg));
    assign move_x = e2 > neg_sy;
    assign move_y = e2 < sx_e;
    assign err_step = err_reg - (move_x ? ERR_W'(span_y_reg) : '0)
                              + (move_y ? ERR_W'(span_x_reg) : '0);
    assign row_base = cur_y_reg[10:0] * width_reg;
    assign idx_full = row_base + 22'(cur_x_reg[10:0]);

    // ---------------- configuration clamp ----------------
    logic [12:0] cfg_wide;
    logic [10:0] cfg_clamped;
    assign cfg_wide    = 13'(cfg_data);
    assign cfg_clamped = (cfg_data == 11'd0) ? 11'd1 :
                         (cfg_wide > 13'(MAX_DIM)) ? 11'(MAX_DIM) : cfg_data;

    // ---------------- control and registered outputs ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            width_reg      <= hlr_pkg::WIDTH_RESET;
            height_reg     <= hlr_pkg::HEIGHT_RESET;
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            end_x_reg      <= '0;
            end_y_reg      <= '0;
            span_x_reg     <= '0;
            span_y_reg     <= '0;
            step_x_neg_reg <= 1'b0;
            step_y_neg_reg <= 1'b0;
            err_reg        <= '0;
            colour_reg     <= '0;
            active_reg     <= 1'b0;
            angle_reg      <= '0;
            rho_reg        <= '0;
            sin_reg        <= '0;
            cos_reg        <= '0;
            prod_reg       <= '0;
            vertical_reg   <= 1'b0;
            num_reg        <= '0;
            rem_reg        <= '0;
            den_reg        <= '0;
            div_neg_reg    <= 1'b0;
            den_zero_reg   <= 1'b0;
            div_pass_reg   <= 1'b0;
            cnt_reg        <= '0;
            cen_reg        <= '0;
            q1_reg         <= '0;
            q2_reg         <= '0;
            px1_reg        <= '0;
            py1_reg        <= '0;
            px2_reg        <= '0;
            py2_reg        <= '0;
            out_valid_reg  <= 1'b0;
            we_reg         <= 1'b0;
            last_reg       <= 1'b0;
            px_out_reg     <= '0;
            py_out_reg     <= '0;
            index_reg      <= '0;
            rgb_reg        <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == hlr_pkg::CFG_IMAGE_WIDTH)
                    width_reg <= cfg_clamped;
                else
                    height_reg <= cfg_clamped;
            end

            if (adv_accept)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept && operation == hlr_pkg::OP_START)
                    begin
                        angle_reg  <= ANGLE_BITS'(angle);
                        rho_reg    <= rho;
                        colour_reg <= {red_in, green_in, blue_in};
                        state_reg  <= S_SIN_RD;
                    end
                    else if (in_accept)
                    begin
                        if (!active_reg)
                        begin
                            we_reg     <= 1'b0;
                            last_reg   <= 1'b1;
                            px_out_reg <= '0;
                            py_out_reg <= '0;
                            index_reg  <= '0;
                            rgb_reg    <= '0;
                        end
                        else
                        begin
                            we_reg     <= in_image;
                            last_reg   <= done;
                            px_out_reg <= in_image ? cur_x_reg[9:0] : '0;
                            py_out_reg <= in_image ? cur_y_reg[9:0] : '0;
                            index_reg  <= in_image ? idx_full[19:0] : '0;
                            rgb_reg    <= in_image ? colour_reg : '0;
                            if (done)
                                active_reg <= 1'b0;
                            else
                            begin
                                err_reg <= err_step;
                                if (move_x)
                                    cur_x_reg <= step_x_neg_reg ? cur_x_reg - 1'b1
                                                                : cur_x_reg + 1'b1;
                                if (move_y)
                                    cur_y_reg <= step_y_neg_reg ? cur_y_reg - 1'b1
                                                                : cur_y_reg + 1'b1;
                            end
                        end
                    end
                end
                S_SIN_RD:
                begin
                    state_reg <= S_COS_RD;
                end
                S_COS_RD:
                begin
                    sin_reg   <= angle_reg[ANGLE_BITS-1] ? rom_neg : rom_pos;
                    state_reg <= S_TRIG;
                end
                S_TRIG:
                begin
                    cos_reg   <= cos_angle[ANGLE_BITS-1] ? rom_neg : rom_pos;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    prod_reg     <= $signed({1'b0, width_reg}) * cos_reg;
                    vertical_reg <= (sin_reg == 16'sd0);
                    num_reg      <= mag_of(rho_q);
                    rem_reg      <= '0;
                    den_reg      <= den_sel[15] ? DEN_W'(-den_sel) : DEN_W'(den_sel);
                    den_zero_reg <= (den_sel == 16'sd0);
                    div_neg_reg  <= rho_q[QUO_W-1] ^ den_sel[15];
                    div_pass_reg <= 1'b0;
                    cnt_reg      <= '0;
                    state_reg    <= S_DIV;
                end
                S_DIV:
                begin
                    if (cnt_reg == CNT_W'(NUM_W - 1))
                    begin
                        cnt_reg <= '0;
                        if (!div_pass_reg)
                            q1_reg <= quo;
                        else
                            q2_reg <= quo;
                        if (!div_pass_reg && !vertical_reg)
                        begin
                            // Second endpoint of a sloped line: same divisor, new numerator.
                            num_reg      <= mag_of(num2);
                            rem_reg      <= '0;
                            div_neg_reg  <= num2[QUO_W-1] ^ sin_reg[15];
                            div_pass_reg <= 1'b1;
                        end
                        else
                        begin
                            cen_reg   <= '0;
                            state_reg <= S_CEN;
                        end
                    end
                    else
                    begin
                        num_reg <= quo_mag;
                        rem_reg <= qbit ? DEN_W'(trial - {1'b0, den_reg})
                                        : trial[DEN_W-1:0];
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_CEN:
                begin
                    case (cen_reg)
                        2'd0:    px1_reg <= COORD_BITS'(cen_sat);
                        2'd1:    py1_reg <= COORD_BITS'(cen_sat);
                        2'd2:    px2_reg <= COORD_BITS'(cen_sat);
                        default: py2_reg <= COORD_BITS'(cen_sat);
                    endcase
                    cen_reg <= cen_reg + 1'b1;
                    if (cen_reg == 2'd3)
                        state_reg <= S_ARM;
                end
                S_ARM:
                begin
                    span_x_reg     <= sx_new;
                    span_y_reg     <= sy_new;
                    step_x_neg_reg <= !($signed(px1_reg) < $signed(px2_reg));
                    step_y_neg_reg <= !($signed(py1_reg) < $signed(py2_reg));
                    err_reg        <= $signed(ERR_W'(sx_new)) - $signed(ERR_W'(sy_new));
                    cur_x_reg      <= px1_reg;
                    cur_y_reg      <= py1_reg;
                    end_x_reg      <= px2_reg;
                    end_y_reg      <= py2_reg;
                    active_reg     <= 1'b1;
                    state_reg      <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign write_enable = we_reg;
    assign pixel_x      = px_out_reg;
    assign pixel_y      = py_out_reg;
    assign pixel_index  = index_reg;
    assign red_out      = rgb_reg[23:16];
    assign green_out    = rgb_reg[15:8];
    assign blue_out     = rgb_reg[7:0];
    assign last         = last_reg;

endmodule

FILE: rtl/hlr_checker.sv
`include "hough_line_rasterizer_unit_assert.svh"

module hlr_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               operation,
    input logic               out_valid,
    input logic               out_stall,
    input logic               write_enable,
    input logic [9:0]         pixel_x,
    input logic [9:0]         pixel_y,
    input logic [19:0]        pixel_index,
    input logic [7:0]         red_out,
    input logic [7:0]         green_out,
    input logic [7:0]         blue_out,
    input logic               last
);

    logic start_req, advance_req;
    assign start_req   = in_valid && !in_stall && operation == hlr_pkg::OP_START;
    assign advance_req = in_valid && !in_stall && operation == hlr_pkg::OP_ADVANCE;

    // A held result must not change while stalled.
    `HLR_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(pixel_index) && $stable(last) && $stable(write_enable),
        "stalled result changed")

    `HLR_ASSERT_NOW(a_no_write_zero, out_valid && !write_enable,
        pixel_x == 10'd0 && pixel_y == 10'd0 && pixel_index == 20'd0 &&
        red_out == 8'd0 && green_out == 8'd0 && blue_out == 8'd0,
        "result without a write carries nonzero data")

    `HLR_ASSERT_NEXT(a_advance_result, advance_req, out_valid,
        "advance request gave no result")

    `HLR_ASSERT_NEXT(a_start_silent, start_req && !(out_valid && out_stall), !out_valid,
        "start request gave a result")

    `HLR_ASSERT_NEXT(a_start_busy, start_req, in_stall,
        "unit took a request while setting up a line")

endmodule

bind hough_line_rasterizer_unit hlr_checker u_hlr_checker (.*);
